/* hdl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg
// shared types, codes and helpers for the answer-to-reset parser
// ----------------------------------------------------------------------------
package sap_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // byte class codes
  localparam logic [2:0] CLS_TS   = 3'd0;
  localparam logic [2:0] CLS_T0   = 3'd1;
  localparam logic [2:0] CLS_TA   = 3'd2;
  localparam logic [2:0] CLS_TB   = 3'd3;
  localparam logic [2:0] CLS_TC   = 3'd4;
  localparam logic [2:0] CLS_TD   = 3'd5;
  localparam logic [2:0] CLS_HIST = 3'd6;
  localparam logic [2:0] CLS_TCK  = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TS       = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  // configuration register indexes
  localparam logic CFG_EXPECTED_TS = 1'b0;
  localparam logic CFG_CHECK_BYTE  = 1'b1;

  localparam logic [7:0] EXPECTED_TS_RESET = 8'h3b;
  localparam logic [4:0] GROUP_MAX         = 5'd31;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_T0    = 6'b000010,
    PH_IFACE = 6'b000100,
    PH_HIST  = 6'b001000,
    PH_CHECK = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] expected_ts;
    logic       check_byte_present;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] byte_class;
    logic [4:0] group_number;
    logic [5:0] byte_position;
    logic       last;
    logic [1:0] error_code;
    logic [3:0] protocol;
    logic [3:0] historical_count;
    logic [5:0] atr_length;
  } result_t;

  // phase after a byte is consumed, from the updated presence and history
  function automatic phase_t next_phase(logic [3:0] pmask, logic [3:0] hleft, logic chk);
    phase_t ph;
    if (pmask != 4'h0) ph = PH_IFACE;
    else if (hleft != 4'h0) ph = PH_HIST;
    else if (chk) ph = PH_CHECK;
    else ph = PH_DONE;
    return ph;
  endfunction

endpackage

/* hdl/sap_if.sv */
// ----------------------------------------------------------------------------
// sap_item_if, sap_result_if, sap_cfg_if
// valid/ready channels of the answer-to-reset parser
// ----------------------------------------------------------------------------
interface sap_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  modport source (output valid, operation, rx_byte, input ready);
  modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface sap_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] byte_class;
  logic [4:0] group_number;
  logic [5:0] byte_position;
  logic       last;
  logic [1:0] error_code;
  logic [3:0] protocol;
  logic [3:0] historical_count;
  logic [5:0] atr_length;
  modport source (output valid, data_byte, byte_class, group_number, byte_position, last,
                  error_code, protocol, historical_count, atr_length, input ready);
  modport sink (input valid, data_byte, byte_class, group_number, byte_position, last,
                error_code, protocol, historical_count, atr_length, output ready);
endinterface

interface sap_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/sap_in_reg.sv */
// ----------------------------------------------------------------------------
// sap_in_reg
// input register stage, refills in the cycle its beat is taken
// ----------------------------------------------------------------------------
module sap_in_reg (
  input  logic              clk,
  input  logic              rst,
  sap_item_if.sink          item,
  input  logic              take,
  output logic              held,
  output sap_pkg::item_t    data
);

  assign item.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item.valid && item.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      data.operation <= item.operation;
      data.rx_byte   <= item.rx_byte;
    end
  end

endmodule

/* hdl/sap_core.sv */
// ----------------------------------------------------------------------------
// sap_core
// byte classifier, parse state and result register
// ----------------------------------------------------------------------------
module sap_core #(
  parameter int MAX_ATR_BYTES = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              held,
  input  sap_pkg::item_t    data,
  input  sap_pkg::cfg_t     cfg,
  output logic              take,
  sap_result_if.source      result
);

  sap_pkg::phase_t  phase, phase_next;
  logic [3:0]       presence_mask, presence_mask_next;
  logic [3:0]       historical_left, historical_left_next;
  logic [3:0]       historical_total, historical_total_next;
  logic [5:0]       position_count, position_count_next;
  logic [4:0]       group_count, group_count_next;
  logic [3:0]       protocol_value, protocol_value_next;
  logic             ts_matched, ts_matched_next;

  logic              produce;
  logic              rvalid;
  sap_pkg::result_t  res, res_next;
  logic [5:0]        pos_inc;
  logic [7:0]        b;
  logic [2:0]        cls;
  logic [4:0]        grp;
  logic              fin;

  assign b       = data.rx_byte;
  assign pos_inc = position_count + 6'd1;

  always_comb begin
    phase_next            = phase;
    presence_mask_next    = presence_mask;
    historical_left_next  = historical_left;
    historical_total_next = historical_total;
    position_count_next   = position_count;
    group_count_next      = group_count;
    protocol_value_next   = protocol_value;
    ts_matched_next       = ts_matched;
    produce               = 1'b0;
    cls                   = sap_pkg::CLS_TS;
    grp                   = 5'd0;
    fin                   = 1'b0;
    res_next              = '0;

    priority if (data.operation == sap_pkg::OP_START) begin
      phase_next            = sap_pkg::PH_IDLE;
      presence_mask_next    = 4'h0;
      historical_left_next  = 4'h0;
      historical_total_next = 4'h0;
      position_count_next   = 6'd0;
      group_count_next      = 5'd0;
      protocol_value_next   = 4'h0;
      ts_matched_next       = 1'b0;
    end else if (data.operation == sap_pkg::OP_TIMEOUT && phase != sap_pkg::PH_DONE) begin
      phase_next              = sap_pkg::PH_DONE;
      produce                 = 1'b1;
      res_next.byte_position  = position_count;
      res_next.last           = 1'b1;
      res_next.error_code     = sap_pkg::ERR_TIMEOUT;
    end else if (data.operation == sap_pkg::OP_BYTE && phase != sap_pkg::PH_DONE) begin
      produce = 1'b1;
      if (position_count >= 6'(MAX_ATR_BYTES)) begin
        phase_next             = sap_pkg::PH_DONE;
        res_next.data_byte     = b;
        res_next.byte_position = position_count;
        res_next.last          = 1'b1;
        res_next.error_code    = sap_pkg::ERR_TOO_LONG;
      end else begin
        position_count_next = pos_inc;
        unique case (phase)
          sap_pkg::PH_IDLE: begin
            ts_matched_next = (b == cfg.expected_ts);
            cls             = sap_pkg::CLS_TS;
            phase_next      = sap_pkg::PH_T0;
          end
          sap_pkg::PH_T0: begin
            cls                   = sap_pkg::CLS_T0;
            presence_mask_next    = b[7:4];
            historical_left_next  = b[3:0];
            historical_total_next = b[3:0];
            group_count_next      = 5'd1;
            phase_next = sap_pkg::next_phase(b[7:4], b[3:0], cfg.check_byte_present);
          end
          sap_pkg::PH_IFACE: begin
            grp = group_count;
            priority if (presence_mask[0]) begin
              cls                = sap_pkg::CLS_TA;
              presence_mask_next = presence_mask & 4'he;
            end else if (presence_mask[1]) begin
              cls                = sap_pkg::CLS_TB;
              presence_mask_next = presence_mask & 4'hc;
            end else if (presence_mask[2]) begin
              cls                = sap_pkg::CLS_TC;
              presence_mask_next = presence_mask & 4'h8;
            end else begin
              cls = sap_pkg::CLS_TD;
              if (group_count == 5'd1) protocol_value_next = b[3:0];
              presence_mask_next = b[7:4];
              if (group_count < sap_pkg::GROUP_MAX) group_count_next = group_count + 5'd1;
            end
            phase_next = sap_pkg::next_phase(presence_mask_next, historical_left,
                                             cfg.check_byte_present);
          end
          sap_pkg::PH_HIST: begin
            cls = sap_pkg::CLS_HIST;
            if (historical_left != 4'h0) historical_left_next = historical_left - 4'h1;
            phase_next = sap_pkg::next_phase(presence_mask, historical_left_next,
                                             cfg.check_byte_present);
          end
          default: begin
            cls        = sap_pkg::CLS_TCK;
            phase_next = sap_pkg::PH_DONE;
          end
        endcase
        fin                    = (phase_next == sap_pkg::PH_DONE);
        res_next.data_byte     = b;
        res_next.byte_class    = cls;
        res_next.group_number  = grp;
        res_next.byte_position = position_count;
        res_next.last          = fin;
        res_next.error_code    = (fin && !ts_matched_next) ? sap_pkg::ERR_TS
                                                           : sap_pkg::ERR_NONE;
      end
    end else begin
      produce = 1'b0;
    end
    res_next.protocol         = protocol_value_next;
    res_next.historical_count = historical_total_next;
    res_next.atr_length       = position_count_next;
  end

  assign take = held && (!produce || !rvalid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sap_pkg::PH_IDLE;
      presence_mask    <= 4'h0;
      historical_left  <= 4'h0;
      historical_total <= 4'h0;
      position_count   <= 6'd0;
      group_count      <= 5'd0;
      protocol_value   <= 4'h0;
      ts_matched       <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      presence_mask    <= presence_mask_next;
      historical_left  <= historical_left_next;
      historical_total <= historical_total_next;
      position_count   <= position_count_next;
      group_count      <= group_count_next;
      protocol_value   <= protocol_value_next;
      ts_matched       <= ts_matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (take && produce) begin
      rvalid <= 1'b1;
    end else if (result.ready) begin
      rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      res <= res_next;
    end
  end

  assign result.valid            = rvalid;
  assign result.data_byte        = res.data_byte;
  assign result.byte_class       = res.byte_class;
  assign result.group_number     = res.group_number;
  assign result.byte_position    = res.byte_position;
  assign result.last             = res.last;
  assign result.error_code       = res.error_code;
  assign result.protocol         = res.protocol;
  assign result.historical_count = res.historical_count;
  assign result.atr_length       = res.atr_length;

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position_count <= 6'(MAX_ATR_BYTES))
    else $error("position count beyond limit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    take && produce && res_next.last |=> phase == sap_pkg::PH_DONE)
    else $error("final result without end of parse");

  a_group_set: assert property (@(posedge clk) disable iff (rst)
    phase == sap_pkg::PH_IFACE |-> group_count != 5'd0)
    else $error("interface phase with no group");

  a_hist_le: assert property (@(posedge clk) disable iff (rst)
    historical_left <= historical_total)
    else $error("historical count exceeds total");

endmodule

/* hdl/smartcard_atr_parser.sv */
// a beat is held in the input register, then classified into the result register,
// where its result is presented until it is taken
// throughput: one beat per cycle unless a result waits untaken, set by the single
// classify step between the two registers; beats with no result are taken anyway
// reset: rst is synchronous; the parser awaits TS, expected_ts is 0x3b and
// check_byte_present is 0
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// classifies answer-to-reset bytes and reports length, protocol and errors
// ----------------------------------------------------------------------------
module smartcard_atr_parser #(
  parameter int MAX_ATR_BYTES = 40
) (
  input  logic          clk,
  input  logic          rst,
  sap_item_if.sink      item,
  sap_result_if.source  result,
  sap_cfg_if.sink       cfg
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  sap_pkg::cfg_t   cfg_reg;
  // beat held in the input register
  sap_pkg::item_t  in_data;
  logic            in_held;
  // core pulls the held beat
  logic            take;

  // writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.expected_ts        <= sap_pkg::EXPECTED_TS_RESET;
      cfg_reg.check_byte_present <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sap_pkg::CFG_EXPECTED_TS: cfg_reg.expected_ts        <= cfg.data;
        sap_pkg::CFG_CHECK_BYTE:  cfg_reg.check_byte_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input register stage
  sap_in_reg u_in (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .held (in_held),
    .data (in_data)
  );

  // classification, parse state and result register
  sap_core #(
    .MAX_ATR_BYTES (MAX_ATR_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .held   (in_held),
    .data   (in_data),
    .cfg    (cfg_reg),
    .take   (take),
    .result (result)
  );

endmodule
